@@ design/lcr_pkg.sv @@
// Shared widths and class codes of the lexeme class recognizer.
package lcr_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 3;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_KEYWORD = 3'd0,
        CLASS_IDENT   = 3'd1,
        CLASS_INTEGER = 3'd2,
        CLASS_SIGNED  = 3'd3,
        CLASS_QUOTED  = 3'd4,
        CLASS_SIGN    = 3'd5,
        CLASS_UNKNOWN = 3'd6
    } token_class_t;

endpackage

@@ design/lcr_automata.sv @@
// The six character automata, their state registers and the class priority.
module lcr_automata
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lcr_pkg::CHAR_W-1:0]    char_byte,
    input  logic                          last_char,
    output lcr_pkg::token_class_t         token_class
);

    // Keyword trie states.
    localparam logic [3:0] KW_START = 4'd0;
    localparam logic [3:0] KW_B     = 4'd1;
    localparam logic [3:0] KW_BP    = 4'd2;
    localparam logic [3:0] KW_BPM   = 4'd3;
    localparam logic [3:0] KW_W     = 4'd4;
    localparam logic [3:0] KW_WA    = 4'd5;
    localparam logic [3:0] KW_WAI   = 4'd6;
    localparam logic [3:0] KW_WAIT  = 4'd7;
    localparam logic [3:0] KW_A     = 4'd8;
    localparam logic [3:0] KW_AM    = 4'd9;
    localparam logic [3:0] KW_AMP   = 4'd10;
    localparam logic [3:0] KW_F     = 4'd11;
    localparam logic [3:0] KW_FX    = 4'd12;
    localparam logic [3:0] KW_DEAD  = 4'd15;

    // Shared codes of the three-state automata (ident, integer, sign).
    localparam logic [1:0] S3_START  = 2'd0;
    localparam logic [1:0] S3_ACCEPT = 2'd1;
    localparam logic [1:0] S3_DEAD   = 2'd2;

    // Signed-number automaton.
    localparam logic [1:0] SN_START  = 2'd0;
    localparam logic [1:0] SN_SIGN   = 2'd1;
    localparam logic [1:0] SN_ACCEPT = 2'd2;
    localparam logic [1:0] SN_DEAD   = 2'd3;

    // Quoted-text automaton.
    localparam logic [1:0] QT_START  = 2'd0;
    localparam logic [1:0] QT_INSIDE = 2'd1;
    localparam logic [1:0] QT_CLOSED = 2'd2;
    localparam logic [1:0] QT_DEAD   = 2'd3;

    logic [3:0] kw_state_reg,     kw_state_next;
    logic [1:0] ident_state_reg,  ident_state_next;
    logic [1:0] int_state_reg,    int_state_next;
    logic [1:0] sgn_state_reg,    sgn_state_next;
    logic [1:0] quote_state_reg,  quote_state_next;
    logic [1:0] sign_state_reg,   sign_state_next;

    logic is_alpha;
    logic is_digit;
    logic is_print;

    assign is_alpha = ((char_byte >= 8'h61) && (char_byte <= 8'h7A))
                   || ((char_byte >= 8'h41) && (char_byte <= 8'h5A));
    assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    assign is_print = (char_byte >= 8'd32) && (char_byte < 8'd127);

    always_comb
    begin
        kw_state_next = KW_DEAD;
        case (kw_state_reg)
            KW_START:
            begin
                if (char_byte == "b")
                    kw_state_next = KW_B;
                else if (char_byte == "w")
                    kw_state_next = KW_W;
                else if (char_byte == "a")
                    kw_state_next = KW_A;
                else if (char_byte == "f")
                    kw_state_next = KW_F;
            end
            KW_B:   if (char_byte == "p") kw_state_next = KW_BP;
            KW_BP:  if (char_byte == "m") kw_state_next = KW_BPM;
            KW_W:   if (char_byte == "a") kw_state_next = KW_WA;
            KW_WA:  if (char_byte == "i") kw_state_next = KW_WAI;
            KW_WAI: if (char_byte == "t") kw_state_next = KW_WAIT;
            KW_A:   if (char_byte == "m") kw_state_next = KW_AM;
            KW_AM:  if (char_byte == "p") kw_state_next = KW_AMP;
            KW_F:   if (char_byte == "x") kw_state_next = KW_FX;
            default: kw_state_next = KW_DEAD;
        endcase
    end

    always_comb
    begin
        case (ident_state_reg)
            S3_START:  ident_state_next = is_alpha ? S3_ACCEPT : S3_DEAD;
            S3_ACCEPT: ident_state_next = (is_alpha || is_digit || (char_byte == "_"))
                                          ? S3_ACCEPT : S3_DEAD;
            default:   ident_state_next = S3_DEAD;
        endcase

        case (int_state_reg)
            S3_START,
            S3_ACCEPT: int_state_next = is_digit ? S3_ACCEPT : S3_DEAD;
            default:   int_state_next = S3_DEAD;
        endcase

        case (sgn_state_reg)
            SN_START:
            begin
                if ((char_byte == "+") || (char_byte == "-"))
                    sgn_state_next = SN_SIGN;
                else
                    sgn_state_next = is_digit ? SN_ACCEPT : SN_DEAD;
            end
            SN_SIGN,
            SN_ACCEPT: sgn_state_next = is_digit ? SN_ACCEPT : SN_DEAD;
            default:   sgn_state_next = SN_DEAD;
        endcase

        case (quote_state_reg)
            QT_START:  quote_state_next = (char_byte == "\"") ? QT_INSIDE : QT_DEAD;
            QT_INSIDE:
            begin
                if (char_byte == "\"")
                    quote_state_next = QT_CLOSED;
                else
                    quote_state_next = is_print ? QT_INSIDE : QT_DEAD;
            end
            default:   quote_state_next = QT_DEAD;
        endcase

        case (sign_state_reg)
            S3_START:  sign_state_next = ((char_byte == "=") || (char_byte == "(")
                                          || (char_byte == ")")) ? S3_ACCEPT : S3_DEAD;
            default:   sign_state_next = S3_DEAD;
        endcase
    end

    // Priority order: keyword first, unrecognized last.
    always_comb
    begin
        if ((kw_state_next == KW_BPM) || (kw_state_next == KW_WAIT)
            || (kw_state_next == KW_AMP) || (kw_state_next == KW_FX))
            token_class = lcr_pkg::CLASS_KEYWORD;
        else if (ident_state_next == S3_ACCEPT)
            token_class = lcr_pkg::CLASS_IDENT;
        else if (int_state_next == S3_ACCEPT)
            token_class = lcr_pkg::CLASS_INTEGER;
        else if (sgn_state_next == SN_ACCEPT)
            token_class = lcr_pkg::CLASS_SIGNED;
        else if (quote_state_next == QT_CLOSED)
            token_class = lcr_pkg::CLASS_QUOTED;
        else if (sign_state_next == S3_ACCEPT)
            token_class = lcr_pkg::CLASS_SIGN;
        else
            token_class = lcr_pkg::CLASS_UNKNOWN;
    end

    // On the final byte every automaton goes back to its start state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_state_reg    <= KW_START;
            ident_state_reg <= S3_START;
            int_state_reg   <= S3_START;
            sgn_state_reg   <= SN_START;
            quote_state_reg <= QT_START;
            sign_state_reg  <= S3_START;
        end
        else if (step)
        begin
            if (last_char)
            begin
                kw_state_reg    <= KW_START;
                ident_state_reg <= S3_START;
                int_state_reg   <= S3_START;
                sgn_state_reg   <= SN_START;
                quote_state_reg <= QT_START;
                sign_state_reg  <= S3_START;
            end
            else
            begin
                kw_state_reg    <= kw_state_next;
                ident_state_reg <= ident_state_next;
                int_state_reg   <= int_state_next;
                sgn_state_reg   <= sgn_state_next;
                quote_state_reg <= quote_state_next;
                sign_state_reg  <= sign_state_next;
            end
        end
    end

endmodule

@@ design/lexeme_class_recognizer_top.sv @@
// Top level of the lexeme class recognizer: input register, automata, result register.
//
// The recognizer takes a lexeme one byte per beat on the slave stream, with
// s_tlast set on its final byte, and returns one class code on the master
// stream for each lexeme: 0 keyword (bpm, wait, amp, fx), 1 identifier,
// 2 unsigned integer, 3 signed integer, 4 double-quoted text, 5 one of the
// signs = ( ), 6 unrecognized. Six small automata advance in parallel on
// every byte, so the block sustains one byte per clock cycle. A byte is held
// in the input register before it steps the automata, and the class of a
// final byte is written into the output register in that same step, from
// which it is offered on the master stream. The input side keeps accepting
// bytes while a result waits on the master side; only a final byte that
// finds the output register still full stalls.
module lexeme_class_recognizer_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lcr_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] char_byte
    input  logic                               s_tlast,   // last_char
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lcr_pkg::TDATA_OUT_W-1:0]    m_tdata    // [2:0] token_class, [7:3] zero
);

    logic                          in_valid_reg;
    logic [lcr_pkg::CHAR_W-1:0]    in_byte_reg;
    logic                          in_last_reg;

    logic                          out_valid_reg;
    lcr_pkg::token_class_t         out_class_reg;

    logic                          out_free;
    logic                          step;
    lcr_pkg::token_class_t         step_class;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    // A held byte steps the automata unless it is final and the result slot is full.
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || step;

    lcr_automata u_automata
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_byte   (in_byte_reg),
        .last_char   (in_last_reg),
        .token_class (step_class)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[lcr_pkg::CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_class_reg <= step_class;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lcr_pkg::TDATA_OUT_W - lcr_pkg::CLASS_W){1'b0}}, out_class_reg};

endmodule

@@ test/tb_lexeme_class_recognizer_top.sv @@
// Self-checking testbench for the lexeme class recognizer top level.
`timescale 1ns / 100ps

module tb_lexeme_class_recognizer_top;

    // Keyword trie states, one per prefix of bpm, wait, amp and fx.
    localparam logic [3:0] KW_START = 4'd0;
    localparam logic [3:0] KW_B     = 4'd1;
    localparam logic [3:0] KW_BP    = 4'd2;
    localparam logic [3:0] KW_BPM   = 4'd3;
    localparam logic [3:0] KW_W     = 4'd4;
    localparam logic [3:0] KW_WA    = 4'd5;
    localparam logic [3:0] KW_WAI   = 4'd6;
    localparam logic [3:0] KW_WAIT  = 4'd7;
    localparam logic [3:0] KW_A     = 4'd8;
    localparam logic [3:0] KW_AM    = 4'd9;
    localparam logic [3:0] KW_AMP   = 4'd10;
    localparam logic [3:0] KW_F     = 4'd11;
    localparam logic [3:0] KW_FX    = 4'd12;
    localparam logic [3:0] KW_DEAD  = 4'd15;

    // States shared by the identifier, integer and sign automata.
    localparam logic [1:0] RUN_START  = 2'd0;
    localparam logic [1:0] RUN_ACCEPT = 2'd1;
    localparam logic [1:0] RUN_DEAD   = 2'd2;

    // Optionally signed integer automaton.
    localparam logic [1:0] SN_START  = 2'd0;
    localparam logic [1:0] SN_SIGN   = 2'd1;
    localparam logic [1:0] SN_ACCEPT = 2'd2;
    localparam logic [1:0] SN_DEAD   = 2'd3;

    // Quoted text automaton.
    localparam logic [1:0] QT_START  = 2'd0;
    localparam logic [1:0] QT_OPEN   = 2'd1;
    localparam logic [1:0] QT_CLOSED = 2'd2;
    localparam logic [1:0] QT_DEAD   = 2'd3;

    localparam logic [7:0] QUOTE_CH = 8'h22;

    localparam int PHASES       = 4;
    localparam int PHASE_BEATS  = 390;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lcr_pkg::TDATA_IN_W-1:0]  s_tdata = '0;     // [7:0] char_byte
    logic                            s_tlast = 1'b0;   // last_char
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lcr_pkg::TDATA_OUT_W-1:0] m_tdata;          // [2:0] token_class, [7:3] zero

    // Predictor copy of the six automata, all in their start states.
    logic [3:0] kw_state    = KW_START;
    logic [1:0] ident_st    = RUN_START;
    logic [1:0] number_st   = RUN_START;
    logic [1:0] signed_st   = SN_START;
    logic [1:0] quoted_st   = QT_START;
    logic [1:0] punct_st    = RUN_START;

    // Classes still owed by the block, oldest first.
    lcr_pkg::token_class_t expected_classes[$];

    // Bytes of the lexeme being built by the random generator.
    logic [7:0] lexeme_bytes[$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;

    string keywords[4] = '{"bpm", "wait", "amp", "fx"};

    // The directed table: one row per beat. A typed class is given only where
    // it is obvious; every other final beat is scored by the predictor.
    typedef struct {
        logic [7:0]            ch;
        logic                  last;
        bit                    typed;
        lcr_pkg::token_class_t want;
    } directed_beat_t;

    localparam int DIRECTED_BEATS = 23;

    directed_beat_t directed_beats [DIRECTED_BEATS] = '{
        '{"b",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"p",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"m",      1'b1, 1'b1, lcr_pkg::CLASS_KEYWORD},   // first lexeme after reset
        '{"f",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"x",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"a",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"m",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"p",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"Z",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},   // one-letter identifier
        '{"0",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"-",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"9",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"+",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},   // sign with no digits
        '{QUOTE_CH, 1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"~",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},   // highest printable byte
        '{QUOTE_CH, 1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"=",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"(",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{")",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{"=",      1'b0, 1'b0, lcr_pkg::CLASS_UNKNOWN},
        '{")",      1'b1, 1'b0, lcr_pkg::CLASS_UNKNOWN},   // a byte after a sign
        '{8'hFF,    1'b1, 1'b1, lcr_pkg::CLASS_UNKNOWN},   // byte above 127
        '{8'h00,    1'b1, 1'b1, lcr_pkg::CLASS_UNKNOWN}
    };

    int src_idle_by_phase[PHASES]   = '{0, 51, 0, 38};
    int sink_stall_by_phase[PHASES] = '{0, 0, 51, 38};

    lexeme_class_recognizer_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Advances all six automata by one byte. On a final byte the class is
    // picked in priority order and every automaton goes back to its start.
    task automatic step_recognizer(input logic [7:0] c, input logic last,
                                   output logic emit, output lcr_pkg::token_class_t cls);
        logic alpha;
        logic digit;
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit = (c >= "0" && c <= "9");

        case (kw_state)
            KW_START:
                kw_state = (c == "b") ? KW_B : (c == "w") ? KW_W :
                           (c == "a") ? KW_A : (c == "f") ? KW_F : KW_DEAD;
            KW_B:   kw_state = (c == "p") ? KW_BP   : KW_DEAD;
            KW_BP:  kw_state = (c == "m") ? KW_BPM  : KW_DEAD;
            KW_W:   kw_state = (c == "a") ? KW_WA   : KW_DEAD;
            KW_WA:  kw_state = (c == "i") ? KW_WAI  : KW_DEAD;
            KW_WAI: kw_state = (c == "t") ? KW_WAIT : KW_DEAD;
            KW_A:   kw_state = (c == "m") ? KW_AM   : KW_DEAD;
            KW_AM:  kw_state = (c == "p") ? KW_AMP  : KW_DEAD;
            KW_F:   kw_state = (c == "x") ? KW_FX   : KW_DEAD;
            default: kw_state = KW_DEAD;
        endcase

        if (ident_st == RUN_START)
            ident_st = alpha ? RUN_ACCEPT : RUN_DEAD;
        else if (ident_st == RUN_ACCEPT)
            ident_st = (alpha || digit || c == "_") ? RUN_ACCEPT : RUN_DEAD;
        else
            ident_st = RUN_DEAD;

        if (number_st == RUN_START || number_st == RUN_ACCEPT)
            number_st = digit ? RUN_ACCEPT : RUN_DEAD;
        else
            number_st = RUN_DEAD;

        if (signed_st == SN_START)
            signed_st = (c == "+" || c == "-") ? SN_SIGN : digit ? SN_ACCEPT : SN_DEAD;
        else if (signed_st == SN_SIGN || signed_st == SN_ACCEPT)
            signed_st = digit ? SN_ACCEPT : SN_DEAD;
        else
            signed_st = SN_DEAD;

        if (quoted_st == QT_START)
            quoted_st = (c == QUOTE_CH) ? QT_OPEN : QT_DEAD;
        else if (quoted_st == QT_OPEN)
            quoted_st = (c == QUOTE_CH) ? QT_CLOSED :
                        (c >= 8'd32 && c < 8'd127) ? QT_OPEN : QT_DEAD;
        else
            quoted_st = QT_DEAD;

        if (punct_st == RUN_START)
            punct_st = (c == "=" || c == "(" || c == ")") ? RUN_ACCEPT : RUN_DEAD;
        else
            punct_st = RUN_DEAD;

        emit = last;
        cls  = lcr_pkg::CLASS_UNKNOWN;
        if (last)
        begin
            if (kw_state == KW_BPM || kw_state == KW_WAIT ||
                kw_state == KW_AMP || kw_state == KW_FX)
                cls = lcr_pkg::CLASS_KEYWORD;
            else if (ident_st == RUN_ACCEPT)
                cls = lcr_pkg::CLASS_IDENT;
            else if (number_st == RUN_ACCEPT)
                cls = lcr_pkg::CLASS_INTEGER;
            else if (signed_st == SN_ACCEPT)
                cls = lcr_pkg::CLASS_SIGNED;
            else if (quoted_st == QT_CLOSED)
                cls = lcr_pkg::CLASS_QUOTED;
            else if (punct_st == RUN_ACCEPT)
                cls = lcr_pkg::CLASS_SIGN;
            kw_state  = KW_START;
            ident_st  = RUN_START;
            number_st = RUN_START;
            signed_st = SN_START;
            quoted_st = QT_START;
            punct_st  = RUN_START;
        end
    endtask

    // Offers one byte on the slave stream, after a random gap, and waits for
    // the beat to be taken. The predictor steps at the accepting edge.
    task automatic push_byte(input logic [7:0] c, input logic last,
                             input bit typed, input lcr_pkg::token_class_t want);
        logic                  emit;
        lcr_pkg::token_class_t cls;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        step_recognizer(c, last, emit, cls);
        if (emit)
            expected_classes.insert(expected_classes.size(), typed ? want : cls);
        bytes_sent++;
    endtask

    // Appends one byte to the lexeme under construction.
    function automatic void add_byte(input logic [7:0] b);
        lexeme_bytes.insert(lexeme_bytes.size(), b);
    endfunction

    function automatic logic [7:0] random_alpha();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] random_ident_char();
        int r;
        r = $urandom_range(62);
        if (r < 52)
            return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    // Builds one lexeme. Most are well formed with random content; some are
    // near misses, broken by a stray byte, or plain noise over all 256 codes.
    function automatic void compose_lexeme();
        int    kind;
        int    len;
        string kw;
        lexeme_bytes.delete();
        kind = $urandom_range(8);
        case (kind)
            0, 1:
            begin
                kw = keywords[$urandom_range(3)];
                for (int i = 0; i < kw.len(); i++)
                    add_byte(kw[i]);
            end
            2:
            begin
                // A keyword with its last letter dropped or one identifier character added.
                kw = keywords[$urandom_range(3)];
                len = $urandom_range(1) ? kw.len() - 1 : kw.len();
                for (int i = 0; i < len; i++)
                    add_byte(kw[i]);
                if (len == kw.len())
                    add_byte(random_ident_char());
            end
            3:
            begin
                add_byte(random_alpha());
                len = $urandom_range(6);
                for (int i = 0; i < len; i++)
                    add_byte(random_ident_char());
            end
            4:
            begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    add_byte(random_digit());
            end
            5:
            begin
                add_byte($urandom_range(1) ? "+" : "-");
                len = $urandom_range(5);
                for (int i = 0; i < len; i++)
                    add_byte(random_digit());
            end
            6:
            begin
                // Inner bytes may hold a quote, which closes the text early.
                add_byte(QUOTE_CH);
                len = $urandom_range(6);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(126, 32)));
                if ($urandom_range(3) != 0)
                    add_byte(QUOTE_CH);
            end
            7:
            begin
                case ($urandom_range(2))
                    0:       add_byte("=");
                    1:       add_byte("(");
                    default: add_byte(")");
                endcase
                if ($urandom_range(3) == 0)
                    add_byte(8'($urandom_range(126, 32)));
            end
            default:
            begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(255)));
            end
        endcase
        // Now and then a lexeme of any kind but noise gets one byte overwritten.
        if (kind < 8 && $urandom_range(7) == 0)
            lexeme_bytes[$urandom_range(lexeme_bytes.size() - 1)] = 8'($urandom_range(255));
    endfunction

    task automatic send_lexeme();
        for (int i = 0; i < lexeme_bytes.size(); i++)
            push_byte(lexeme_bytes[i], i == lexeme_bytes.size() - 1, 1'b0,
                      lcr_pkg::CLASS_UNKNOWN);
    endtask

    // Receiver: scores every result beat against the oldest expectation,
    // then decides whether to stall for the next cycle. A pending hold-off
    // keeps m_tready low for a long stretch so that the block backs up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_classes.size() == 0)
                begin
                    $error("token_class: no result expected, actual %0d",
                           m_tdata[lcr_pkg::CLASS_W-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    lcr_pkg::token_class_t want;
                    want = expected_classes.pop_front();
                    if (m_tdata[lcr_pkg::CLASS_W-1:0] !== want)
                    begin
                        $error("token_class: expected %0d, actual %0d",
                               want, m_tdata[lcr_pkg::CLASS_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Main sequence: reset, the directed table, then random lexemes in four
    // phases of source idling and sink stalls, then a drain of all outstanding results.
    initial
    begin
        int phase_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_BEATS; i++)
            push_byte(directed_beats[i].ch, directed_beats[i].last,
                      directed_beats[i].typed, directed_beats[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            src_idle_pct   = src_idle_by_phase[p];
            sink_stall_pct = sink_stall_by_phase[p];
            // In the first phase the receiver holds off while the sender
            // keeps offering beats back to back, so the input must stall.
            if (p == 0)
                hold_left = HOLD_CYCLES;
            phase_end = bytes_sent + PHASE_BEATS;
            while (bytes_sent < phase_end)
            begin
                compose_lexeme();
                send_lexeme();
            end
        end

        s_tvalid       <= 1'b0;
        sink_stall_pct = 0;
        while (expected_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ lexeme_class_recognizer_top.f @@
design/lcr_pkg.sv
design/lcr_automata.sv
design/lexeme_class_recognizer_top.sv
test/tb_lexeme_class_recognizer_top.sv
